// ===== hw/rtl/rfcs_pkg.sv =====
// Shared constants, widths and types for the ring chi-square block.
// Depends on nothing; every rfcs_* module and the top level import it.
`timescale 1ns / 1ps

package rfcs_pkg;

   localparam int COORD_BITS     = 18;
   localparam int MAX_HITS       = 64;
   localparam int COUNT_BITS     = 7;
   localparam int RADIUS_BITS    = 16;
   localparam int SUM_BITS       = 44;
   localparam int MIN_HITS       = 4;
   localparam int DOF_LOSS       = 3;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam int ABS_BITS       = COORD_BITS;
   localparam int SQ_BITS        = 2 * ABS_BITS;
   localparam int ROOT_BITS      = ABS_BITS + 1;
   localparam int RADICAND_BITS  = 2 * ROOT_BITS;
   localparam int REM_BITS       = ROOT_BITS + 2;
   localparam int RESID_BITS     = (ROOT_BITS > RADIUS_BITS) ? ROOT_BITS : RADIUS_BITS;
   localparam int SQR_BITS       = 2 * RESID_BITS;
   localparam int ACC_BITS       = ((SQR_BITS > SUM_BITS) ? SQR_BITS : SUM_BITS) + 1;
   localparam int STEP_MAX       = (ROOT_BITS > SUM_BITS) ? ROOT_BITS : SUM_BITS;
   localparam int STEP_BITS      = $clog2(STEP_MAX);

   typedef struct packed {
      logic                   accum;
      logic                   last;
      logic                   too_few;
      logic                   overflow;
      logic [COUNT_BITS-1:0]  divisor;
      logic [ABS_BITS-1:0]    abs_x;
      logic [ABS_BITS-1:0]    abs_y;
      logic [RADIUS_BITS-1:0] radius;
   } hit_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] chi_square;
      logic                too_few_hits;
      logic                hit_overflow;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUMSQ,
      ST_ROOT,
      ST_RESID,
      ST_SQRES,
      ST_ACCUM,
      ST_DIVIDE,
      ST_EMIT
   } back_state_type;

endpackage

// ===== hw/rtl/rfcs_front.sv =====
// Front end: takes hit beats, counts hits per ring and classifies each beat.
// Depends on rfcs_pkg; feeds rfcs_queue.
`timescale 1ns / 1ps

module rfcs_front import rfcs_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  logic signed [COORD_BITS-1:0] req_hit_x,
   input  logic signed [COORD_BITS-1:0] req_hit_y,
   input  logic signed [COORD_BITS-1:0] req_center_x,
   input  logic signed [COORD_BITS-1:0] req_center_y,
   input  logic        [RADIUS_BITS-1:0] req_ring_radius,
   input  logic                         req_last_hit,
   input  queue_status_type             queue_status,
   output logic                         req_full,
   output logic                         entry_push,
   output hit_entry_type                entry
);

   logic [COUNT_BITS-1:0] count_ff, count_in, count_after;
   logic                  ovf_ff, ovf_in;
   logic                  accept, over;
   logic signed [COORD_BITS:0] dx, dy;

   assign req_full = queue_status.full;
   assign accept   = req_push && !queue_status.full;
   assign over     = count_ff >= COUNT_BITS'(MAX_HITS);
   assign count_after = over ? count_ff : count_ff + COUNT_BITS'(1);

   assign dx = {req_center_x[COORD_BITS-1], req_center_x}
             - {req_hit_x[COORD_BITS-1], req_hit_x};
   assign dy = {req_center_y[COORD_BITS-1], req_center_y}
             - {req_hit_y[COORD_BITS-1], req_hit_y};

   always_comb begin
      entry.accum    = !over;
      entry.last     = req_last_hit;
      entry.too_few  = count_after < COUNT_BITS'(MIN_HITS);
      entry.overflow = ovf_ff || over;
      entry.divisor  = count_after - COUNT_BITS'(DOF_LOSS);
      entry.abs_x    = dx[COORD_BITS] ? ABS_BITS'(-dx) : ABS_BITS'(dx);
      entry.abs_y    = dy[COORD_BITS] ? ABS_BITS'(-dy) : ABS_BITS'(dy);
      entry.radius   = req_ring_radius;
   end

   // drop overflow beats unless they close the ring
   assign entry_push = accept && (!over || req_last_hit);

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req_last_hit) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            count_in = count_after;
            ovf_in   = ovf_ff || over;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ===== hw/rtl/rfcs_queue.sv =====
// Short queue of classified hits between front and back end.
// Depends on rfcs_pkg for the entry type and depth.
`timescale 1ns / 1ps

module rfcs_queue import rfcs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr,
   input  hit_entry_type    wr_data,
   input  logic             rd,
   output hit_entry_type    rd_data,
   output queue_status_type status
);

   hit_entry_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_BITS:0]     count_ff;
   logic                        do_wr, do_rd;

   assign status.empty = count_ff == '0;
   assign status.full  = count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
   assign do_wr   = wr && !status.full;
   assign do_rd   = rd && !status.empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1))
                       ? '0 : wr_ptr_ff + QUEUE_PTR_BITS'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1))
                       ? '0 : rd_ptr_ff + QUEUE_PTR_BITS'(1);
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + (QUEUE_PTR_BITS+1)'(1);
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - (QUEUE_PTR_BITS+1)'(1);
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

// ===== hw/rtl/rfcs_back.sv =====
// Back end: squares, bit-serial square root, residual, saturating sum,
// bit-serial division per ring and the result register. Depends on rfcs_pkg.
`timescale 1ns / 1ps

module rfcs_back import rfcs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type queue_status,
   input  hit_entry_type    entry,
   output logic             queue_pop,
   input  logic             rsp_pop,
   output logic             rsp_valid,
   output result_type       result
);

   back_state_type state_ff, state_in;

   hit_entry_type             ent_ff;
   logic [SQ_BITS-1:0]        sqx_ff, sqy_ff;
   logic [RADICAND_BITS-1:0]  radicand_ff;
   logic [REM_BITS-1:0]       rem_ff, rem_shift, trial, rem_in;
   logic [ROOT_BITS-1:0]      root_ff, root_in;
   logic                      root_ge;
   logic [RESID_BITS-1:0]     resid_ff, root_ext, rad_ext;
   logic [SQR_BITS-1:0]       sqr_ff;
   logic [SUM_BITS-1:0]       sum_ff, sum_next, quot_ff;
   logic [ACC_BITS-1:0]       acc;
   logic [COUNT_BITS-1:0]     drem_ff;
   logic [COUNT_BITS:0]       drem_shift, drem_in;
   logic                      div_ge;
   logic [STEP_BITS-1:0]      step_ff;
   logic                      rsp_valid_ff;
   result_type                result_ff;
   logic                      slot_free, load_result, root_done, div_done;

   assign slot_free = !rsp_valid_ff || rsp_pop;
   assign root_done = step_ff == STEP_BITS'(ROOT_BITS - 1);
   assign div_done  = step_ff == STEP_BITS'(SUM_BITS - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_status.empty) begin
               if (entry.accum)        state_in = ST_SQUARE;
               else if (entry.too_few) state_in = ST_EMIT;
               else                    state_in = ST_DIVIDE;
            end
         end
         ST_SQUARE: state_in = ST_SUMSQ;
         ST_SUMSQ:  state_in = ST_ROOT;
         ST_ROOT: begin
            if (root_done) state_in = ST_RESID;
         end
         ST_RESID:  state_in = ST_SQRES;
         ST_SQRES:  state_in = ST_ACCUM;
         ST_ACCUM: begin
            if (!ent_ff.last)       state_in = ST_IDLE;
            else if (ent_ff.too_few) state_in = ST_EMIT;
            else                    state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      queue_pop   = 1'b0;
      load_result = 1'b0;
      case (state_ff)
         ST_IDLE: queue_pop   = !queue_status.empty;
         ST_EMIT: load_result = slot_free;
         default: begin
            queue_pop   = 1'b0;
            load_result = 1'b0;
         end
      endcase
   end

   assign rem_shift = {rem_ff[REM_BITS-3:0], radicand_ff[RADICAND_BITS-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign root_ge   = rem_shift >= trial;
   assign rem_in    = root_ge ? rem_shift - trial : rem_shift;
   assign root_in   = {root_ff[ROOT_BITS-2:0], root_ge};

   assign root_ext  = RESID_BITS'(root_ff);
   assign rad_ext   = RESID_BITS'(ent_ff.radius);

   assign acc      = ACC_BITS'(sum_ff) + ACC_BITS'(sqr_ff);
   assign sum_next = (acc[ACC_BITS-1:SUM_BITS] != '0) ? '1 : acc[SUM_BITS-1:0];

   assign drem_shift = {drem_ff, quot_ff[SUM_BITS-1]};
   assign div_ge     = drem_shift >= {1'b0, ent_ff.divisor};
   assign drem_in    = div_ge ? drem_shift - {1'b0, ent_ff.divisor} : drem_shift;

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (queue_pop) begin
               ent_ff  <= entry;
               quot_ff <= sum_ff;
               drem_ff <= '0;
               step_ff <= '0;
            end
         end
         ST_SQUARE: begin
            sqx_ff <= SQ_BITS'(ent_ff.abs_x) * SQ_BITS'(ent_ff.abs_x);
            sqy_ff <= SQ_BITS'(ent_ff.abs_y) * SQ_BITS'(ent_ff.abs_y);
         end
         ST_SUMSQ: begin
            radicand_ff <= RADICAND_BITS'(sqx_ff) + RADICAND_BITS'(sqy_ff);
            rem_ff      <= '0;
            root_ff     <= '0;
            step_ff     <= '0;
         end
         ST_ROOT: begin
            radicand_ff <= {radicand_ff[RADICAND_BITS-3:0], 2'b00};
            rem_ff      <= rem_in;
            root_ff     <= root_in;
            step_ff     <= step_ff + STEP_BITS'(1);
         end
         ST_RESID: begin
            resid_ff <= (root_ext >= rad_ext) ? root_ext - rad_ext : rad_ext - root_ext;
         end
         ST_SQRES: begin
            sqr_ff <= SQR_BITS'(resid_ff) * SQR_BITS'(resid_ff);
         end
         ST_ACCUM: begin
            quot_ff <= sum_next;
            drem_ff <= '0;
            step_ff <= '0;
         end
         ST_DIVIDE: begin
            quot_ff <= {quot_ff[SUM_BITS-2:0], div_ge};
            drem_ff <= drem_in[COUNT_BITS-1:0];
            step_ff <= step_ff + STEP_BITS'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_result) begin
         result_ff.chi_square   <= ent_ff.too_few ? '0 : quot_ff;
         result_ff.too_few_hits <= ent_ff.too_few;
         result_ff.hit_overflow <= ent_ff.overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_ACCUM) begin
            sum_ff <= sum_next;
         end else if (load_result) begin
            sum_ff <= '0;
         end
         if (load_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> ent_ff.divisor != '0)
      else $error("division entered with zero divisor");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      load_result |=> rsp_valid_ff && sum_ff == '0)
      else $error("result load did not show a beat or clear the sum");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      queue_pop |=> state_ff != ST_IDLE)
      else $error("entry popped without leaving idle");

endmodule

// ===== hw/rtl/ring_fit_chi_square.sv =====
// Top level of the ring chi-square block: front end, hit queue, back end.
// Depends on rfcs_pkg, rfcs_front, rfcs_queue and rfcs_back.
//
//   channel   handshake          payload
//   req_      push / full        hit_x hit_y center_x center_y ring_radius last_hit
//   rsp_      empty / pop        chi_square too_few_hits hit_overflow
//
// A hit that is summed goes through squaring, the one-bit-per-cycle square root,
// the residual, its square and the saturating sum in the back end.
// The last hit of a ring also goes through the serial divider unless the ring has too few hits.
// Hits beyond MAX_HITS that do not close a ring are dropped in the front end.
// A four-entry queue decouples the two ends; full rises when it fills.
// Reset is synchronous and clears counters, sum, queue and result valid.
`timescale 1ns / 1ps

module ring_fit_chi_square import rfcs_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [COORD_BITS-1:0]  req_hit_x,
   input  logic signed [COORD_BITS-1:0]  req_hit_y,
   input  logic signed [COORD_BITS-1:0]  req_center_x,
   input  logic signed [COORD_BITS-1:0]  req_center_y,
   input  logic        [RADIUS_BITS-1:0] req_ring_radius,
   input  logic                          req_last_hit,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic        [SUM_BITS-1:0]    rsp_chi_square,
   output logic                          rsp_too_few_hits,
   output logic                          rsp_hit_overflow
);

   queue_status_type q_status;
   hit_entry_type    push_entry, pop_entry;
   logic             entry_push, queue_pop, rsp_valid;
   result_type       result;

   rfcs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_hit_x       (req_hit_x),
      .req_hit_y       (req_hit_y),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_ring_radius (req_ring_radius),
      .req_last_hit    (req_last_hit),
      .queue_status    (q_status),
      .req_full        (req_full),
      .entry_push      (entry_push),
      .entry           (push_entry)
   );

   rfcs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (entry_push),
      .wr_data (push_entry),
      .rd      (queue_pop),
      .rd_data (pop_entry),
      .status  (q_status)
   );

   rfcs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (q_status),
      .entry        (pop_entry),
      .queue_pop    (queue_pop),
      .rsp_pop      (rsp_pop),
      .rsp_valid    (rsp_valid),
      .result       (result)
   );

   assign rsp_empty        = !rsp_valid;
   assign rsp_chi_square   = result.chi_square;
   assign rsp_too_few_hits = result.too_few_hits;
   assign rsp_hit_overflow = result.hit_overflow;

endmodule
